@@ rtl/ikmv_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and helpers for the intersection kernel mat-vec block.
// Used by every module of the block but ikmv_ram; depends on nothing.
package ikmv_pkg;

  localparam int MAX_ROWS_DEF = 256;
  localparam int MAX_COLS_DEF = 16;

  localparam int OPC_W  = 3;
  localparam int ROWF_W = 8;
  localparam int COLF_W = 4;
  localparam int FEAT_W = 16;
  localparam int VEC_W  = 32;
  localparam int RES_W  = 64;
  localparam int CIDX_W = 2;
  localparam int CFGD_W = 32;
  localparam int NROW_W = 9;
  localparam int NCOL_W = 5;

  typedef enum logic [OPC_W-1:0] {
    OP_LOAD_FEAT = 3'd0,
    OP_LOAD_RANK = 3'd1,
    OP_LOAD_VEC  = 3'd2,
    OP_START     = 3'd3,
    OP_READ      = 3'd4
  } op_t;

  typedef enum logic [CIDX_W-1:0] {
    CFG_ROWS  = 2'd0,
    CFG_COLS  = 2'd1,
    CFG_NOISE = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_COL_START,
    S_SUF_RANK,
    S_SUF_VEC,
    S_SUF_ACC,
    S_MAC_START,
    S_MAC_RANK,
    S_MAC_RD,
    S_MAC_MUL,
    S_MAC_WR,
    S_NOI_START,
    S_NOI_RD,
    S_NOI_MUL,
    S_NOI_WR,
    S_REPLY
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic take;
    logic k_zero;
    logic col_init;
    logic col_next;
    logic clr_step;
    logic suf_init;
    logic suf_rank;
    logic suf_vec;
    logic suf_acc;
    logic mac_rank;
    logic mac_rd;
    logic mac_mul;
    logic mac_wr;
    logic noi_rd;
    logic noi_mul;
    logic noi_wr;
    logic res_rd;
    logic out_load;
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic n_zero;
    logic m_zero;
    logic clr_last;
    logic suf_last;
    logic row_last;
    logic col_last;
  } dp_sts_t;

  // Signed 64-bit add, saturated to the signed range
  function automatic logic signed [RES_W-1:0] sat_add(input logic signed [RES_W-1:0] a,
                                                      input logic signed [RES_W-1:0] b);
    logic signed [RES_W:0] sum;
    logic signed [RES_W-1:0] res;
    sum = {a[RES_W-1], a} + {b[RES_W-1], b};
    if (sum[RES_W] != sum[RES_W-1]) begin
      res = sum[RES_W] ? {1'b1, {(RES_W-1){1'b0}}} : {1'b0, {(RES_W-1){1'b1}}};
    end else begin
      res = sum[RES_W-1:0];
    end
    return res;
  endfunction

endpackage

@@ rtl/ikmv_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module ikmv_ram #(
  parameter int W = 8,
  parameter int D = 256
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  // Write port, read port holds its data until the next read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/ikmv_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencer for the mat-vec block: clear pass, per-column suffix and MAC walks,
// diagonal pass and reply. Depends on ikmv_pkg.
module ikmv_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [2:0]         in_opcode,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  ikmv_pkg::dp_sts_t  sts,
  output ikmv_pkg::dp_cmd_t  cmd,
  output ikmv_pkg::state_t   state_o
);
  import ikmv_pkg::*;

  state_t state_r, state_nxt;
  logic   start_r, start_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   slot_free;
  op_t    op;

  assign op        = op_t'(in_opcode);
  assign accept    = in_valid && (state_r == S_IDLE);
  assign slot_free = !out_valid_r || !out_stall;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (op == OP_START) begin
            state_nxt = S_CLEAR;
          end else if (op == OP_READ) begin
            state_nxt = S_REPLY;
          end
        end
      end
      S_CLEAR: begin
        if (sts.clr_last) begin
          if (!start_r) begin
            state_nxt = S_IDLE;
          end else if (sts.m_zero || sts.n_zero) begin
            state_nxt = S_NOI_START;
          end else begin
            state_nxt = S_COL_START;
          end
        end
      end
      S_COL_START: state_nxt = S_SUF_RANK;
      S_SUF_RANK:  state_nxt = S_SUF_VEC;
      S_SUF_VEC:   state_nxt = S_SUF_ACC;
      S_SUF_ACC:   state_nxt = sts.suf_last ? S_MAC_START : S_SUF_RANK;
      S_MAC_START: state_nxt = S_MAC_RANK;
      S_MAC_RANK:  state_nxt = S_MAC_RD;
      S_MAC_RD:    state_nxt = S_MAC_MUL;
      S_MAC_MUL:   state_nxt = S_MAC_WR;
      S_MAC_WR: begin
        if (sts.row_last) begin
          state_nxt = sts.col_last ? S_NOI_START : S_COL_START;
        end else begin
          state_nxt = S_MAC_RANK;
        end
      end
      S_NOI_START: state_nxt = sts.n_zero ? S_REPLY : S_NOI_RD;
      S_NOI_RD:    state_nxt = S_NOI_MUL;
      S_NOI_MUL:   state_nxt = S_NOI_WR;
      S_NOI_WR:    state_nxt = sts.row_last ? S_REPLY : S_NOI_RD;
      S_REPLY:     state_nxt = slot_free ? S_IDLE : S_REPLY;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // Command outputs
  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.take = 1'b1;
          if (op == OP_START) begin
            cmd.k_zero = 1'b1;
          end
          if (op == OP_READ) begin
            cmd.res_rd = 1'b1;
          end
        end
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        cmd.col_init = 1'b1;
      end
      S_COL_START: cmd.suf_init = 1'b1;
      S_SUF_RANK:  cmd.suf_rank = 1'b1;
      S_SUF_VEC:   cmd.suf_vec  = 1'b1;
      S_SUF_ACC:   cmd.suf_acc  = 1'b1;
      S_MAC_START: cmd.k_zero   = 1'b1;
      S_MAC_RANK:  cmd.mac_rank = 1'b1;
      S_MAC_RD:    cmd.mac_rd   = 1'b1;
      S_MAC_MUL:   cmd.mac_mul  = 1'b1;
      S_MAC_WR: begin
        cmd.mac_wr   = 1'b1;
        cmd.col_next = sts.row_last;
      end
      S_NOI_START: cmd.k_zero  = 1'b1;
      S_NOI_RD:    cmd.noi_rd  = 1'b1;
      S_NOI_MUL:   cmd.noi_mul = 1'b1;
      S_NOI_WR:    cmd.noi_wr  = 1'b1;
      S_REPLY:     cmd.out_load = slot_free;
      default:     cmd = '0;
    endcase
  end

  // Start flag and output valid
  always_comb begin
    start_nxt = start_r;
    if (accept && (op == OP_START)) begin
      start_nxt = 1'b1;
    end else if ((state_r == S_REPLY) && slot_free) begin
      start_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign state_o   = state_r;

endmodule

@@ rtl/ikmv_dp.sv @@
`timescale 1ns / 1ps
// Datapath: configuration registers, stores, counters, multipliers and
// saturating accumulate. Depends on ikmv_pkg and ikmv_ram.
module ikmv_dp #(
  parameter int MAX_ROWS = ikmv_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = ikmv_pkg::MAX_COLS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  ikmv_pkg::dp_cmd_t                       cmd,
  output ikmv_pkg::dp_sts_t                       sts,
  input  logic [2:0]                              in_opcode,
  input  logic [ikmv_pkg::ROWF_W-1:0]             in_row,
  input  logic [ikmv_pkg::COLF_W-1:0]             in_col,
  input  logic [ikmv_pkg::FEAT_W-1:0]             in_feature_value,
  input  logic [ikmv_pkg::ROWF_W-1:0]             in_rank_row,
  input  logic signed [ikmv_pkg::VEC_W-1:0]       in_vector_value,
  input  logic                                    cfg_we,
  input  logic [ikmv_pkg::CIDX_W-1:0]             cfg_index,
  input  logic [ikmv_pkg::CFGD_W-1:0]             cfg_wdata,
  output logic signed [ikmv_pkg::RES_W-1:0]       out_result_value,
  output logic [ikmv_pkg::ROWF_W-1:0]             out_result_row,
  output logic                                    out_done_res
);
  import ikmv_pkg::*;

  localparam int ROW_AW = $clog2(MAX_ROWS);
  localparam int CNT_W  = $clog2(MAX_ROWS + 1);
  localparam int COL_AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CCNT_W = $clog2(MAX_COLS + 1);
  localparam int FA_D   = MAX_ROWS * MAX_COLS;
  localparam int FA_W   = $clog2(FA_D);
  localparam int SUF_W  = VEC_W + ROW_AW;
  localparam logic [NROW_W-1:0] ROWS_RST = NROW_W'((MAX_ROWS > 511) ? 511 : MAX_ROWS);
  localparam logic [NCOL_W-1:0] COLS_RST = NCOL_W'((MAX_COLS > 31) ? 31 : MAX_COLS);

  // Configuration registers
  logic [NROW_W-1:0] rows_r;
  logic [NCOL_W-1:0] cols_r;
  logic [CFGD_W-1:0] noise_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r  <= ROWS_RST;
      cols_r  <= COLS_RST;
      noise_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ROWS:  rows_r  <= cfg_wdata[NROW_W-1:0];
        CFG_COLS:  cols_r  <= cfg_wdata[NCOL_W-1:0];
        CFG_NOISE: noise_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Clamp row and column counts to the store size
  logic [CNT_W-1:0]  n_w;
  logic [CCNT_W-1:0] m_w;
  assign n_w = (32'(rows_r) > MAX_ROWS) ? CNT_W'(MAX_ROWS) : CNT_W'(rows_r);
  assign m_w = (32'(cols_r) > MAX_COLS) ? CCNT_W'(MAX_COLS) : CCNT_W'(cols_r);

  // Rank entries reduced modulo the store depth MAX_ROWS at load
  logic [ROW_AW-1:0] rank_mod [256];
  for (genvar gi = 0; gi < 256; gi++) begin : g_rank_mod
    assign rank_mod[gi] = ROW_AW'(gi % MAX_ROWS);
  end

  // Load decode
  op_t  op;
  logic row_ok, col_ok;
  assign op     = op_t'(in_opcode);
  assign row_ok = (32'(in_row) < MAX_ROWS);
  assign col_ok = (32'(in_col) < MAX_COLS);

  // Walk counters
  logic [CNT_W-1:0]  k_r, km1;
  logic [CCNT_W-1:0] c_r;
  logic [ROW_AW-1:0] k_idx, km1_idx;
  logic [COL_AW-1:0] c_idx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0;
      c_r <= '0;
    end else begin
      if (cmd.k_zero) begin
        k_r <= '0;
      end else if (cmd.suf_init) begin
        k_r <= n_w;
      end else if (cmd.clr_step || cmd.mac_wr || cmd.noi_wr) begin
        k_r <= k_r + CNT_W'(1);
      end else if (cmd.suf_acc) begin
        k_r <= km1;
      end
      if (cmd.col_init) begin
        c_r <= '0;
      end else if (cmd.col_next) begin
        c_r <= c_r + CCNT_W'(1);
      end
    end
  end

  assign km1     = k_r - CNT_W'(1);
  assign k_idx   = k_r[ROW_AW-1:0];
  assign km1_idx = km1[ROW_AW-1:0];
  assign c_idx   = c_r[COL_AW-1:0];

  // Rank store
  logic [FA_W-1:0]   ld_addr;
  logic [ROW_AW-1:0] who;
  logic [ROW_AW-1:0] rank_ridx;
  assign ld_addr   = FA_W'(32'(in_row) * MAX_COLS + 32'(in_col));
  assign rank_ridx = cmd.suf_rank ? km1_idx : k_idx;

  ikmv_ram #(.W(ROW_AW), .D(FA_D)) u_rank (
    .clk   (clk),
    .we    (cmd.take && (op == OP_LOAD_RANK) && row_ok && col_ok),
    .waddr (ld_addr),
    .wdata (rank_mod[in_rank_row]),
    .re    (cmd.suf_rank || cmd.mac_rank),
    .raddr (FA_W'(32'(rank_ridx) * MAX_COLS + 32'(c_idx))),
    .rdata (who)
  );

  // Feature store
  logic [FEAT_W-1:0] feat_q;
  ikmv_ram #(.W(FEAT_W), .D(FA_D)) u_feat (
    .clk   (clk),
    .we    (cmd.take && (op == OP_LOAD_FEAT) && row_ok && col_ok),
    .waddr (ld_addr),
    .wdata (in_feature_value),
    .re    (cmd.mac_rd),
    .raddr (FA_W'(32'(who) * MAX_COLS + 32'(c_idx))),
    .rdata (feat_q)
  );

  // Vector store
  logic signed [VEC_W-1:0] vec_q;
  ikmv_ram #(.W(VEC_W), .D(MAX_ROWS)) u_vec (
    .clk   (clk),
    .we    (cmd.take && (op == OP_LOAD_VEC) && row_ok),
    .waddr (ROW_AW'(in_row)),
    .wdata (in_vector_value),
    .re    (cmd.suf_vec || cmd.mac_rd || cmd.noi_rd),
    .raddr (cmd.noi_rd ? k_idx : who),
    .rdata (vec_q)
  );

  // Suffix sums of the vector in rank order
  logic signed [SUF_W-1:0] s_r, s_sum, suf_q;
  assign s_sum = s_r + SUF_W'(vec_q);

  always_ff @(posedge clk) begin
    if (cmd.suf_init) begin
      s_r <= '0;
    end else if (cmd.suf_acc) begin
      s_r <= s_sum;
    end
  end

  ikmv_ram #(.W(SUF_W), .D(MAX_ROWS)) u_suf (
    .clk   (clk),
    .we    (cmd.suf_acc),
    .waddr (km1_idx),
    .wdata (s_sum),
    .re    (cmd.mac_rd),
    .raddr (k_idx),
    .rdata (suf_q)
  );

  // Full-width products of feature, suffix, vector and sigma
  logic signed [FEAT_W+SUF_W:0]  mul_suf;
  logic signed [FEAT_W+VEC_W:0]  mul_vec;
  logic signed [CFGD_W+VEC_W:0]  mul_noi;
  assign mul_suf = $signed({1'b0, feat_q}) * suf_q;
  assign mul_vec = $signed({1'b0, feat_q}) * vec_q;
  assign mul_noi = $signed({1'b0, noise_r}) * vec_q;

  // Products, one register stage after the multipliers
  logic signed [RES_W-1:0] p_suf_r, p_vec_r, run_r, term;

  always_ff @(posedge clk) begin
    if (cmd.mac_mul) begin
      p_suf_r <= RES_W'(mul_suf);
      p_vec_r <= RES_W'(mul_vec);
    end else if (cmd.noi_mul) begin
      p_vec_r <= RES_W'(mul_noi);
    end
    if (cmd.k_zero) begin
      run_r <= '0;
    end else if (cmd.mac_wr) begin
      run_r <= run_r + p_vec_r;
    end
  end

  assign term = run_r + p_suf_r;

  // Result store: cleared, accumulated, read back
  logic signed [RES_W-1:0] res_q, res_wd;
  logic [ROW_AW-1:0]       res_ra;

  always_comb begin
    if (cmd.mac_wr) begin
      res_wd = sat_add(res_q, term);
    end else if (cmd.noi_wr) begin
      res_wd = sat_add(res_q, p_vec_r);
    end else begin
      res_wd = '0;
    end
    if (cmd.res_rd) begin
      res_ra = ROW_AW'(in_row);
    end else if (cmd.mac_rd) begin
      res_ra = who;
    end else begin
      res_ra = k_idx;
    end
  end

  ikmv_ram #(.W(RES_W), .D(MAX_ROWS)) u_res (
    .clk   (clk),
    .we    (cmd.clr_step || cmd.mac_wr || cmd.noi_wr),
    .waddr (cmd.mac_wr ? who : k_idx),
    .wdata (res_wd),
    .re    (cmd.res_rd || cmd.mac_rd || cmd.noi_rd),
    .raddr (res_ra),
    .rdata (res_q)
  );

  // Hold request details for the reply
  logic              rd_kind_r, bad_r;
  logic [ROWF_W-1:0] row_r;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      rd_kind_r <= (op == OP_READ);
      bad_r     <= !row_ok;
      row_r     <= in_row;
    end
  end

  // Output register
  logic signed [RES_W-1:0] out_value_r;
  logic [ROWF_W-1:0]       out_row_r;
  logic                    out_done_r;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_value_r <= (rd_kind_r && !bad_r) ? res_q : '0;
      out_row_r   <= rd_kind_r ? row_r : '0;
      out_done_r  <= !rd_kind_r;
    end
  end

  assign out_result_value = out_value_r;
  assign out_result_row   = out_row_r;
  assign out_done_res     = out_done_r;

  // Status
  assign sts.n_zero   = (n_w == '0);
  assign sts.m_zero   = (m_w == '0);
  assign sts.clr_last = (k_r == CNT_W'(MAX_ROWS - 1));
  assign sts.suf_last = (k_r == CNT_W'(1));
  assign sts.row_last = ((k_r + CNT_W'(1)) == n_w);
  assign sts.col_last = ((c_r + CCNT_W'(1)) == m_w);

endmodule

@@ rtl/intersection_kernel_matvec.sv @@
`timescale 1ns / 1ps
// Intersection kernel matrix-vector product, (K + sigma*I) * y.
// Usage: push requests on the in_ channel (valid/stall). Opcodes load a feature
// element, a rank entry or a vector element (no reply; the sequencer stays idle),
// start the product, or read one result row. Start and read each give one reply
// on the out_ channel (valid/stall); start replies with done_res set and zero
// value and row. Configuration (rows, columns, sigma) is to be written on the
// cfg_ port only while idle; the block does not enforce this. cfg_ready is
// always high. A read loads the registered result read into the output register
// in the reply state. A start clears the result memory (one row a cycle), then
// per column runs a suffix step (rank, vector, accumulate) and a MAC step (rank,
// read, multiply, write) per row through the single read port of each store,
// then a diagonal step (read, multiply, write) per row.
// One request is in work at a time; in_stall is high whenever the sequencer is
// not idle.
// Reset: synchronous, active low; after reset the whole result memory is cleared
// while in_stall stays high.
// A stalled reply is held in the output register; the sequencer waits until the
// register is free before loading the next reply.
module intersection_kernel_matvec #(
  parameter int MAX_ROWS = ikmv_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = ikmv_pkg::MAX_COLS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [ikmv_pkg::OPC_W-1:0]        in_opcode,
  input  logic [ikmv_pkg::ROWF_W-1:0]       in_row,
  input  logic [ikmv_pkg::COLF_W-1:0]       in_col,
  input  logic [ikmv_pkg::FEAT_W-1:0]       in_feature_value,
  input  logic [ikmv_pkg::ROWF_W-1:0]       in_rank_row,
  input  logic signed [ikmv_pkg::VEC_W-1:0] in_vector_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [ikmv_pkg::RES_W-1:0] out_result_value,
  output logic [ikmv_pkg::ROWF_W-1:0]       out_result_row,
  output logic                              out_done_res,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ikmv_pkg::CIDX_W-1:0]       cfg_index,
  input  logic [ikmv_pkg::CFGD_W-1:0]       cfg_wdata
);
  import ikmv_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  state_t  state;

  assign cfg_ready = 1'b1;

  ikmv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd),
    .state_o   (state)
  );

  ikmv_dp #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_opcode        (in_opcode),
    .in_row           (in_row),
    .in_col           (in_col),
    .in_feature_value (in_feature_value),
    .in_rank_row      (in_rank_row),
    .in_vector_value  (in_vector_value),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .out_result_value (out_result_value),
    .out_result_row   (out_result_row),
    .out_done_res     (out_done_res)
  );

  // A new reply only comes out of the reply state
  a_reply_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state == S_REPLY))
    else $error("reply raised outside reply state");

  // Start completion carries zero value and row
  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_done_res) |-> (out_result_value == '0 && out_result_row == '0))
    else $error("start reply carries data");

  // Reset enters the clearing pass
  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> (state == S_CLEAR))
    else $error("reset did not start clearing pass");

endmodule
